/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while reset is high
`define DMBF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// clocked property, checked during reset too
`define DMBF_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

/* hw/rtl/dmbf_pkg.sv */
package dmbf_pkg;

   localparam int STORE_BYTES_DEFAULT = 64;

   localparam int DATA_W  = 8;
   localparam int COUNT_W = 7;
   localparam int LIMIT_W = 6;
   localparam int BSTATE_W = 2;

   localparam logic [DATA_W-1:0]  NEWLINE_BYTE = 8'h0A;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT  = 7'd127;
   localparam logic [LIMIT_W-1:0] MAX_MESSAGES_RESET = 6'd16;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_MAX_MESSAGES = 1'b0;

   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_TUSER_W = 3;

   localparam int RSP_BSTATE_LSB = 8;
   localparam int RSP_PEND_LSB   = 10;
   localparam int RSP_PAD_W      = RSP_TDATA_W - RSP_PEND_LSB - COUNT_W;

   typedef enum logic [1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_STATUS = 2'd2
   } command_type;

   typedef enum logic [2:0] {
      RC_MSG_BYTE     = 3'd0,
      RC_EMPTY_MSG    = 3'd1,
      RC_BUF_EMPTY    = 3'd2,
      RC_NO_DELIM     = 3'd3,
      RC_STORED       = 3'd4,
      RC_DROPPED_FULL = 3'd5,
      RC_REFUSED      = 3'd6,
      RC_STATUS       = 3'd7
   } result_code_type;

   typedef enum logic [1:0] {
      BUF_OK    = 2'd0,
      BUF_EMPTY = 2'd1,
      BUF_FULL  = 2'd2
   } buffer_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

endpackage

/* hw/rtl/dmbf_csr.sv */
module dmbf_csr
   import dmbf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [LIMIT_W-1:0]    max_messages
);

   logic [LIMIT_W-1:0] max_messages_ff;
   logic [LIMIT_W-1:0] max_messages_in;
   logic               wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      max_messages_in = max_messages_ff;
      if (wr_en && csr_paddr[2] == REG_MAX_MESSAGES) begin
         max_messages_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_messages_ff <= MAX_MESSAGES_RESET;
      end else begin
         max_messages_ff <= max_messages_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_MAX_MESSAGES: csr_prdata = CSR_DATA_W'(max_messages_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign max_messages = max_messages_ff;

endmodule

/* hw/rtl/delimited_message_byte_fifo.sv */
// channel  dir  handshake             payload
// req      in   req_tvalid/tready     tdata {delimiter, data_in}, tuser {first, command}
// rsp      out  rsp_tvalid/tready     tdata {pending, buffer_state, data_out}, tuser code
// csr      in   APB psel/penable      max_messages at byte address 0
//
// Push and status are answered directly from idle. A pop reads and compares each byte
// in turn (through the delimiter, or every stored byte when it is missing), then reads
// and emits each message byte, through the single registered read port of the byte store and the one compare unit.
// Reset is synchronous and clears pointers, count and control; the store is not cleared.
// A result waits in the output register while rsp_tready is low; a new item is
// taken only when that register is empty or being emptied.
module delimited_message_byte_fifo
   import dmbf_pkg::*;
#(
   parameter int STORE_BYTES = STORE_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // data_in[7:0], delimiter[15:8]
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // command[1:0], first_of_string[2]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // data_out[7:0], buffer_state[9:8],
                                               // pending_messages[16:10], zero pad
   output logic                   rsp_tlast,
   output logic [RSP_TUSER_W-1:0] rsp_tuser,   // result_code[2:0]
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int PTR_W = $clog2(STORE_BYTES);

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(STORE_BYTES - 1)) ? '0 : p + 1'b1;
   endfunction

   logic [LIMIT_W-1:0] max_messages;

   dmbf_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .max_messages (max_messages)
   );

   logic [DATA_W-1:0] store_mem [STORE_BYTES];
   logic [DATA_W-1:0] rd_data_ff;
   logic [PTR_W-1:0]  rd_addr;
   logic              mem_we;

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               refusing_ff, refusing_in;
   logic [PTR_W-1:0]   scan_ptr_ff, scan_ptr_in;
   logic [PTR_W-1:0]   scan_n_ff, scan_n_in;
   logic [PTR_W-1:0]   stored_ff, stored_in;
   logic [DATA_W-1:0]  delim_ff, delim_in;
   logic [PTR_W-1:0]   emit_ptr_ff, emit_ptr_in;
   logic [PTR_W-1:0]   emit_left_ff, emit_left_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;
   result_code_type        rsp_code_ff, rsp_code_in;
   buffer_state_type       rsp_bstate_ff, rsp_bstate_in;
   logic [COUNT_W-1:0]     rsp_pend_ff, rsp_pend_in;

   logic                   out_free;
   logic                   out_load;
   logic                   accept;
   command_type            req_cmd;
   logic                   req_first;
   logic [DATA_W-1:0]      req_data;
   logic [DATA_W-1:0]      req_delim;
   logic [PTR_W:0]         stored_calc;
   logic [PTR_W-1:0]       scan_n_inc;

   assign req_cmd   = command_type'(req_tuser[1:0]);
   assign req_first = req_tuser[2];
   assign req_data  = req_tdata[DATA_W-1:0];
   assign req_delim = req_tdata[2*DATA_W-1:DATA_W];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign scan_n_inc = scan_n_ff + 1'b1;

   always_comb begin
      if (wr_ptr_ff >= rd_ptr_ff) begin
         stored_calc = {1'b0, wr_ptr_ff} - {1'b0, rd_ptr_ff};
      end else begin
         stored_calc = {1'b0, wr_ptr_ff} + (PTR_W+1)'(STORE_BYTES) - {1'b0, rd_ptr_ff};
      end
   end

   always_comb begin
      state_in     = state_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      refusing_in  = refusing_ff;
      scan_ptr_in  = scan_ptr_ff;
      scan_n_in    = scan_n_ff;
      stored_in    = stored_ff;
      delim_in     = delim_ff;
      emit_ptr_in  = emit_ptr_ff;
      emit_left_in = emit_left_ff;
      mem_we       = 1'b0;
      out_load     = 1'b0;
      rsp_data_in  = '0;
      rsp_last_in  = 1'b1;
      rsp_code_in  = RC_STATUS;
      rd_addr      = scan_ptr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_PUSH: begin
                     out_load = 1'b1;
                     if (req_first) begin
                        refusing_in = (count_ff >= {1'b0, max_messages});
                     end
                     if (refusing_in) begin
                        rsp_code_in = RC_REFUSED;
                     end else begin
                        if (req_data == NEWLINE_BYTE && count_ff < COUNT_LIMIT) begin
                           count_in = count_ff + 1'b1;
                        end
                        if (ptr_next(wr_ptr_ff) != rd_ptr_ff) begin
                           mem_we      = 1'b1;
                           wr_ptr_in   = ptr_next(wr_ptr_ff);
                           rsp_code_in = RC_STORED;
                        end else begin
                           rsp_code_in = RC_DROPPED_FULL;
                        end
                     end
                  end
                  CMD_POP: begin
                     if (count_ff == '0) begin
                        out_load    = 1'b1;
                        rsp_code_in = RC_BUF_EMPTY;
                     end else if (stored_calc == '0) begin
                        out_load    = 1'b1;
                        rsp_code_in = RC_NO_DELIM;
                     end else begin
                        stored_in   = stored_calc[PTR_W-1:0];
                        scan_ptr_in = rd_ptr_ff;
                        scan_n_in   = '0;
                        delim_in    = req_delim;
                        state_in    = ST_SCAN_RD;
                     end
                  end
                  CMD_STATUS: begin
                     out_load    = 1'b1;
                     rsp_code_in = RC_STATUS;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (rd_data_ff == delim_ff) begin
               if (out_free || scan_n_ff != '0) begin
                  rd_ptr_in = ptr_next(scan_ptr_ff);
                  count_in  = count_ff - 1'b1;
                  if (scan_n_ff == '0) begin
                     out_load    = 1'b1;
                     rsp_code_in = RC_EMPTY_MSG;
                     state_in    = ST_IDLE;
                  end else begin
                     emit_ptr_in  = rd_ptr_ff;
                     emit_left_in = scan_n_ff;
                     state_in     = ST_EMIT_RD;
                  end
               end
            end else if (scan_n_inc == stored_ff) begin
               if (out_free) begin
                  out_load    = 1'b1;
                  rsp_code_in = RC_NO_DELIM;
                  state_in    = ST_IDLE;
               end
            end else begin
               scan_n_in   = scan_n_inc;
               scan_ptr_in = ptr_next(scan_ptr_ff);
               state_in    = ST_SCAN_RD;
            end
         end
         ST_EMIT_RD: begin
            rd_addr  = emit_ptr_ff;
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            rd_addr = emit_ptr_ff;
            if (out_free) begin
               out_load     = 1'b1;
               rsp_data_in  = rd_data_ff;
               rsp_code_in  = RC_MSG_BYTE;
               rsp_last_in  = (emit_left_ff == PTR_W'(1));
               emit_left_in = emit_left_ff - 1'b1;
               emit_ptr_in  = ptr_next(emit_ptr_ff);
               state_in     = (emit_left_ff == PTR_W'(1)) ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (count_in == '0) begin
         rsp_bstate_in = BUF_EMPTY;
      end else if (ptr_next(wr_ptr_in) == rd_ptr_in) begin
         rsp_bstate_in = BUF_FULL;
      end else begin
         rsp_bstate_in = BUF_OK;
      end
      rsp_pend_in = count_in;

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[wr_ptr_ff] <= req_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         refusing_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         refusing_ff  <= refusing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff  <= scan_ptr_in;
      scan_n_ff    <= scan_n_in;
      stored_ff    <= stored_in;
      delim_ff     <= delim_in;
      emit_ptr_ff  <= emit_ptr_in;
      emit_left_ff <= emit_left_in;
      if (out_load) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_code_ff   <= rsp_code_in;
         rsp_bstate_ff <= rsp_bstate_in;
         rsp_pend_ff   <= rsp_pend_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_code_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_pend_ff, rsp_bstate_ff, rsp_data_ff};

endmodule

/* hw/rtl/dmbf_checker.sv */
`include "assert_macros.svh"

module dmbf_checker
   import dmbf_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tlast,
   input logic [RSP_TUSER_W-1:0] rsp_tuser
);

   logic                   is_byte;
   logic [COUNT_W-1:0]     pend;
   logic [BSTATE_W-1:0]    bstate;

   assign is_byte = (rsp_tuser == RC_MSG_BYTE);
   assign pend    = rsp_tdata[RSP_PEND_LSB +: COUNT_W];
   assign bstate  = rsp_tdata[RSP_BSTATE_LSB +: BSTATE_W];

   `DMBF_ASSERT_ALWAYS(a_reset_clears_valid, clock, reset |=> !rsp_tvalid)

   `DMBF_ASSERT(a_valid_holds, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)

   `DMBF_ASSERT(a_single_result_last, clock, reset, rsp_tvalid && !is_byte |-> rsp_tlast)

   `DMBF_ASSERT(a_non_byte_zero_data, clock, reset,
      rsp_tvalid && !is_byte |-> rsp_tdata[DATA_W-1:0] == '0)

   `DMBF_ASSERT(a_empty_matches_count, clock, reset,
      rsp_tvalid |-> ((pend == '0) == (bstate == BUF_EMPTY)))

endmodule

bind delimited_message_byte_fifo dmbf_checker u_dmbf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
